// ----- sv/dre_pkg.sv -----
// ----------------------------------------------------------------------------
// DNS reply A-record extractor package
// Shared types and constants: parse phases, verdict codes, header offsets and
// the structs that pass between the input stage, the parser and the result
// register.
// ----------------------------------------------------------------------------
package dre_pkg;

   // Verdict codes reported on the result channel.
   localparam logic [2:0] ST_FOUND   = 3'd0;
   localparam logic [2:0] ST_NXNAME  = 3'd1;
   localparam logic [2:0] ST_SRVFAIL = 3'd2;
   localparam logic [2:0] ST_NOA     = 3'd3;
   localparam logic [2:0] ST_DISCARD = 3'd4;

   // Byte offsets inside the fixed 12-byte header.
   localparam int HDR_ID_HI    = 0;
   localparam int HDR_ID_LO    = 1;
   localparam int HDR_FLAGS_HI = 2;
   localparam int HDR_FLAGS_LO = 3;
   localparam int HDR_ANCNT_HI = 6;
   localparam int HDR_ANCNT_LO = 7;
   localparam int HDR_LAST     = 11;

   // Header field masks and record constants.
   localparam logic [15:0] FLAG_QR       = 16'h8000;
   localparam logic [3:0]  RCODE_NXNAME  = 4'h3;
   localparam logic [7:0]  LABEL_PTR     = 8'hc0;
   localparam logic [15:0] RR_TYPE_A     = 16'd1;
   localparam logic [15:0] RR_LEN_A      = 16'd4;

   // Offsets inside the question trailer and the answer record header.
   localparam logic [3:0] QFIXED_LEN   = 4'd4;
   localparam logic [3:0] AF_TYPE_HI   = 4'd0;
   localparam logic [3:0] AF_TYPE_LO   = 4'd1;
   localparam logic [3:0] AF_RDLEN_HI  = 4'd8;
   localparam logic [3:0] AF_RDLEN_LO  = 4'd9;
   localparam logic [3:0] AFIXED_LEN   = 4'd10;
   localparam logic [3:0] ADDR_LEN     = 4'd4;

   // Parse phases, one-hot.
   typedef enum logic [11:0] {
      PH_HEADER = 12'b0000_0000_0001,
      PH_QNAME  = 12'b0000_0000_0010,
      PH_QLABEL = 12'b0000_0000_0100,
      PH_QPTR   = 12'b0000_0000_1000,
      PH_QFIXED = 12'b0000_0001_0000,
      PH_ANAME  = 12'b0000_0010_0000,
      PH_ALABEL = 12'b0000_0100_0000,
      PH_APTR   = 12'b0000_1000_0000,
      PH_AFIXED = 12'b0001_0000_0000,
      PH_ADATA  = 12'b0010_0000_0000,
      PH_ASKIP  = 12'b0100_0000_0000,
      PH_DONE   = 12'b1000_0000_0000
   } phase_type;

   // One reply byte as held in the input register.
   typedef struct packed {
      logic [7:0] reply_byte;
      logic       last_byte;
   } in_item_type;

   // One verdict.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] ipv4_address;
   } result_type;

endpackage

// ----- sv/dns_reply_a_record_extractor_top.sv -----
// Path: a final byte accepted into the input register is parsed there and its verdict
// is loaded into the result register, which raises rsp_valid.
// Throughput: one reply byte per cycle, set by the single parse pass between
// the input register and the result register; a final byte waits while a verdict is stalled.
// Reset: synchronous, active high; returns the parse state to the header phase,
// clears both valid flags and sets expected_id to zero.
// ----------------------------------------------------------------------------
// DNS reply A-record extractor
// Parses a DNS reply one byte per transaction and gives one verdict with the
// first usable A-record address on the final byte of each datagram.
// ----------------------------------------------------------------------------
module dns_reply_a_record_extractor_top #(
   parameter int MAX_REPLY_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_reply_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_ipv4_address,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import dre_pkg::*;

   logic        rsp_free;
   logic        fire;
   in_item_type item;
   result_type  result;

   // Input register.
   dre_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_reply_byte (req_reply_byte),
      .req_last_byte  (req_last_byte),
      .rsp_free       (rsp_free),
      .fire           (fire),
      .item           (item)
   );

   // Parse state and verdict logic.
   dre_parser #(
      .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (item),
      .result      (result)
   );

   // Result register.
   dre_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (fire && item.last_byte),
      .result           (result),
      .rsp_free         (rsp_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_ipv4_address (rsp_ipv4_address)
   );

endmodule

// ----- sv/dre_in_reg.sv -----
// ----------------------------------------------------------------------------
// DNS reply extractor input register
// Holds one accepted reply byte and releases it to the parser. A final byte
// is only released when the result register can take the verdict.
// ----------------------------------------------------------------------------
module dre_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_reply_byte,
   input  logic                 req_last_byte,
   input  logic                 rsp_free,
   output logic                 fire,
   output dre_pkg::in_item_type item
);
   import dre_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   in_item_type item_ff;

   // The held byte moves on unless it ends a datagram and the result is blocked.
   assign fire      = in_valid_ff && (!item_ff.last_byte || rsp_free);
   assign req_stall = in_valid_ff && !fire;
   assign item      = item_ff;

   // The register refills whenever it is not stalled.
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload loads on each accepted transaction.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.reply_byte <= req_reply_byte;
         item_ff.last_byte  <= req_last_byte;
      end
   end

endmodule

// ----- sv/dre_parser.sv -----
// ----------------------------------------------------------------------------
// DNS reply extractor parser
// Byte-at-a-time parse state: header checks, question skip and answer walk.
// Produces the verdict for the byte being consumed and clears itself after
// the final byte of a datagram.
// ----------------------------------------------------------------------------
module dre_parser #(
   parameter int MAX_REPLY_BYTES = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  logic                 fire,
   input  dre_pkg::in_item_type item,
   output dre_pkg::result_type  result
);
   import dre_pkg::*;

   localparam int CNT_W = $clog2(MAX_REPLY_BYTES + 1);

   logic [15:0]  expected_id_ff;

   phase_type    phase_ff,         phase_in;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]  header_flags_ff,  header_flags_in;
   logic [15:0]  answers_left_ff,  answers_left_in;
   logic [5:0]   label_rem_ff,     label_rem_in;
   logic [3:0]   field_offset_ff,  field_offset_in;
   logic [15:0]  record_type_ff,   record_type_in;
   logic [15:0]  record_length_ff, record_length_in;
   logic [31:0]  address_ff,       address_in;
   logic [2:0]   verdict_ff,       verdict_in;
   logic         id_match_ff,      id_match_in;

   logic [7:0]   b;
   logic [15:0]  answers_dec;

   assign b           = item.reply_byte;
   assign answers_dec = answers_left_ff - 16'd1;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= 16'd0;
      end else if (csr_wr_en) begin
         expected_id_ff <= csr_wr_data;
      end
   end

   // Next parse state for the byte in the input register.
   always_comb begin
      phase_in         = phase_ff;
      byte_count_in    = byte_count_ff;
      header_flags_in  = header_flags_ff;
      answers_left_in  = answers_left_ff;
      label_rem_in     = label_rem_ff;
      field_offset_in  = field_offset_ff;
      record_type_in   = record_type_ff;
      record_length_in = record_length_ff;
      address_in       = address_ff;
      verdict_in       = verdict_ff;
      id_match_in      = id_match_ff;

      if (byte_count_ff < CNT_W'(MAX_REPLY_BYTES)) begin
         byte_count_in = byte_count_ff + CNT_W'(1);
         case (phase_ff)
            PH_HEADER: begin
               if (byte_count_ff == CNT_W'(HDR_ID_HI)) begin
                  header_flags_in = {b, 8'h00};
               end else if (byte_count_ff == CNT_W'(HDR_ID_LO)) begin
                  id_match_in = ((header_flags_ff | {8'h00, b}) == expected_id_ff);
               end else if (byte_count_ff == CNT_W'(HDR_FLAGS_HI)) begin
                  header_flags_in = {b, 8'h00};
               end else if (byte_count_ff == CNT_W'(HDR_FLAGS_LO)) begin
                  header_flags_in = header_flags_ff | {8'h00, b};
               end else if (byte_count_ff == CNT_W'(HDR_ANCNT_HI)) begin
                  answers_left_in = {b, 8'h00};
               end else if (byte_count_ff == CNT_W'(HDR_ANCNT_LO)) begin
                  answers_left_in = answers_left_ff | {8'h00, b};
               end else if (byte_count_ff == CNT_W'(HDR_LAST)) begin
                  // Header checks, in priority order.
                  if (!id_match_ff || ((header_flags_ff & FLAG_QR) == 16'd0)) begin
                     verdict_in = ST_DISCARD;
                     phase_in   = PH_DONE;
                  end else if (header_flags_ff[3:0] == RCODE_NXNAME) begin
                     verdict_in = ST_NXNAME;
                     phase_in   = PH_DONE;
                  end else if (header_flags_ff[3:0] != 4'd0) begin
                     verdict_in = ST_SRVFAIL;
                     phase_in   = PH_DONE;
                  end else if (answers_left_ff == 16'd0) begin
                     verdict_in = ST_NOA;
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in = PH_QNAME;
                  end
               end
            end
            PH_QNAME, PH_ANAME: begin
               // Label length, end of name or compression pointer.
               if (b == 8'd0) begin
                  phase_in        = (phase_ff == PH_ANAME) ? PH_AFIXED : PH_QFIXED;
                  field_offset_in = 4'd0;
               end else if ((b & LABEL_PTR) == LABEL_PTR) begin
                  phase_in = (phase_ff == PH_ANAME) ? PH_APTR : PH_QPTR;
               end else if ((b & LABEL_PTR) != 8'd0) begin
                  verdict_in = (phase_ff == PH_ANAME) ? ST_NOA : ST_DISCARD;
                  phase_in   = PH_DONE;
               end else begin
                  label_rem_in = b[5:0];
                  phase_in     = (phase_ff == PH_ANAME) ? PH_ALABEL : PH_QLABEL;
               end
            end
            PH_QLABEL, PH_ALABEL: begin
               label_rem_in = label_rem_ff - 6'd1;
               if (label_rem_in == 6'd0) begin
                  phase_in = (phase_ff == PH_QLABEL) ? PH_QNAME : PH_ANAME;
               end
            end
            PH_QPTR: begin
               phase_in        = PH_QFIXED;
               field_offset_in = 4'd0;
            end
            PH_APTR: begin
               phase_in        = PH_AFIXED;
               field_offset_in = 4'd0;
            end
            PH_QFIXED: begin
               // Question type and class are skipped.
               field_offset_in = field_offset_ff + 4'd1;
               if (field_offset_in >= QFIXED_LEN) begin
                  verdict_in = ST_NOA;
                  phase_in   = PH_ANAME;
               end
            end
            PH_AFIXED: begin
               // Capture type and RDATA length from the record header.
               if (field_offset_ff == AF_TYPE_HI) begin
                  record_type_in = {b, 8'h00};
               end else if (field_offset_ff == AF_TYPE_LO) begin
                  record_type_in = record_type_ff | {8'h00, b};
               end else if (field_offset_ff == AF_RDLEN_HI) begin
                  record_length_in = {b, 8'h00};
               end else if (field_offset_ff == AF_RDLEN_LO) begin
                  record_length_in = record_length_ff | {8'h00, b};
               end
               field_offset_in = field_offset_ff + 4'd1;
               if (field_offset_in >= AFIXED_LEN) begin
                  field_offset_in = 4'd0;
                  address_in      = 32'd0;
                  if (record_type_in == RR_TYPE_A && record_length_in == RR_LEN_A) begin
                     phase_in = PH_ADATA;
                  end else if (record_length_in == 16'd0) begin
                     answers_left_in = answers_dec;
                     if (answers_dec == 16'd0) begin
                        verdict_in = ST_NOA;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_ANAME;
                     end
                  end else begin
                     phase_in = PH_ASKIP;
                  end
               end
            end
            PH_ADATA: begin
               address_in      = {address_ff[23:0], b};
               field_offset_in = field_offset_ff + 4'd1;
               if (field_offset_in >= ADDR_LEN) begin
                  verdict_in = ST_FOUND;
                  phase_in   = PH_DONE;
               end
            end
            PH_ASKIP: begin
               // Skip RDATA of a record that is not a usable A record.
               record_length_in = record_length_ff - 16'd1;
               if (record_length_in == 16'd0) begin
                  answers_left_in = answers_dec;
                  if (answers_dec == 16'd0) begin
                     verdict_in = ST_NOA;
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in = PH_ANAME;
                  end
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Verdict for a final byte comes from the updated state.
   assign result.status       = verdict_in;
   assign result.ipv4_address = (verdict_in == ST_FOUND) ? address_in : 32'd0;

   // Parse state: cleared by reset and after each final byte.
   always_ff @(posedge clock) begin
      if (reset || (fire && item.last_byte)) begin
         phase_ff         <= PH_HEADER;
         byte_count_ff    <= '0;
         header_flags_ff  <= 16'd0;
         answers_left_ff  <= 16'd0;
         label_rem_ff     <= 6'd0;
         field_offset_ff  <= 4'd0;
         record_type_ff   <= 16'd0;
         record_length_ff <= 16'd0;
         address_ff       <= 32'd0;
         verdict_ff       <= ST_DISCARD;
         id_match_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         byte_count_ff    <= byte_count_in;
         header_flags_ff  <= header_flags_in;
         answers_left_ff  <= answers_left_in;
         label_rem_ff     <= label_rem_in;
         field_offset_ff  <= field_offset_in;
         record_type_ff   <= record_type_in;
         record_length_ff <= record_length_in;
         address_ff       <= address_in;
         verdict_ff       <= verdict_in;
         id_match_ff      <= id_match_in;
      end
   end

endmodule

// ----- sv/dre_rsp_reg.sv -----
// ----------------------------------------------------------------------------
// DNS reply extractor result register
// Holds one verdict until the result channel takes it and tells the input
// stage whether a new verdict can be stored.
// ----------------------------------------------------------------------------
module dre_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  dre_pkg::result_type result,
   output logic                rsp_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_ipv4_address
);
   import dre_pkg::*;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type result_ff;

   // The slot is free when empty or being taken in this cycle.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload loads only with a new verdict.
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = result_ff.status;
   assign rsp_ipv4_address = result_ff.ipv4_address;

endmodule

// ----- sv/dre_checker.sv -----
// ----------------------------------------------------------------------------
// DNS reply extractor checker
// Port-level checks on the result channel and the input stall, bound to the top level.
// ----------------------------------------------------------------------------
module dre_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_ipv4_address
);
   import dre_pkg::*;

   // A stalled verdict stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_ipv4_address))
      else $error("stalled verdict changed");

   // An address is only reported with a found verdict.
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_FOUND) |-> rsp_ipv4_address == 32'd0)
      else $error("address without found verdict");

   // Verdicts stay within the defined codes.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_FOUND || rsp_status == ST_NXNAME
         || rsp_status == ST_SRVFAIL || rsp_status == ST_NOA
         || rsp_status == ST_DISCARD))
      else $error("undefined verdict code");

   // Reset empties both stages.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("stage not empty after reset");

   // The input side never stalls while the result register is empty.
   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

bind dns_reply_a_record_extractor_top dre_checker u_dre_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_ipv4_address (rsp_ipv4_address)
);
